// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: hdl/dpt_pkg.sv
package dpt_pkg;
  localparam int VALUE_BITS = 64;
  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  typedef logic [VALUE_BITS-1:0] word_t;

  localparam logic [63:0] LIM_SMALL = 64'd316349281;
  localparam logic [63:0] LIM_MID   = 64'd4759123141;

  typedef enum logic [1:0] {SET_SMALL, SET_MID, SET_LARGE} wset_t;

  function automatic logic [31:0] witness(input wset_t set, input logic [2:0] idx);
    logic [31:0] w;
    w = 32'd0;
    unique case (set)
      SET_SMALL: w = (idx == 3'd0) ? 32'd11000544 : 32'd31481107;
      SET_MID: begin
        unique case (idx)
          3'd0: w = 32'd2;
          3'd1: w = 32'd7;
          default: w = 32'd61;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0: w = 32'd2;
          3'd1: w = 32'd325;
          3'd2: w = 32'd9375;
          3'd3: w = 32'd28178;
          3'd4: w = 32'd450775;
          3'd5: w = 32'd9780504;
          default: w = 32'd1795265022;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [2:0] wcount(input wset_t set);
    logic [2:0] c;
    unique case (set)
      SET_SMALL: c = 3'd2;
      SET_MID: c = 3'd3;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

  // Handshake of the modular multiplier and the modular reducer.
  typedef struct packed {
    logic start;
  } mm_ctl_t;

  typedef struct packed {
    logic done;
  } mm_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BASE, ST_RED, ST_POWSQ_GO, ST_POWSQ_W, ST_POWMUL_GO, ST_POWMUL_W,
    ST_CHK, ST_SQ_GO, ST_SQ_W, ST_NEXT, ST_OUT
  } state_t;
endpackage

// File: hdl/deterministic_primality_test.sv
// Channel   | Handshake                      | Payload
// request   | candidate_valid/candidate_ready | candidate[63:0]
// result    | is_prime_valid/is_prime_ready  | is_prime
//
// One candidate at a time. Small (below 4) and even candidates go from the base
// check straight to the result; otherwise each witness runs a base reduction and
// then bit-serial modular multiplies (one bit per cycle). A witness needs at most
// about 128 multiplies, and a candidate is tested against at most 7 witnesses.
// Reset clears the sequencer; a stalled result holds in its register while the
// next candidate runs, and the sequencer waits at its end until the register frees.
module deterministic_primality_test import dpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        candidate_valid,
  output logic        candidate_ready,
  input  logic [63:0] candidate,
  output logic        is_prime_valid,
  input  logic        is_prime_ready,
  output logic        is_prime
);
  state_t state, state_next;
  word_t n, nm1, t, pb, e, res, ms_a, ms_b;
  wset_t wset;
  logic [2:0] widx;
  logic [CNT_BITS-1:0] s, k;
  logic verdict;
  mm_ctl_t mctl, rctl;
  mm_sts_t msts, rsts;
  word_t mr, rr;
  logic sel_sq;
  word_t nin, nin_m1;
  logic [CNT_BITS-1:0] tz;
  logic out_free;

  assign nin = word_t'(candidate);
  assign nin_m1 = nin - word_t'(1);
  assign out_free = !is_prime_valid || is_prime_ready;

  // Trailing zeros of candidate-1: the lowest set bit wins.
  always_comb begin
    tz = '0;
    for (int i = VALUE_BITS - 1; i >= 0; i--) begin
      if (nin_m1[i]) tz = CNT_BITS'(i);
    end
  end

  dpt_modmul u_mul (.clk, .rst, .ctl(mctl), .a(ms_a), .b(ms_b), .m(n), .sts(msts), .r(mr));
  dpt_modred u_red (.clk, .rst, .ctl(rctl), .x(word_t'(witness(wset, widx))), .m(n),
                    .sts(rsts), .r(rr));

  always_comb begin
    ms_a = sel_sq ? pb : res;
    ms_b = pb;
    if (state == ST_SQ_GO || state == ST_SQ_W) begin
      ms_a = t;
      ms_b = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    mctl.start = 1'b0;
    rctl.start = 1'b0;
    unique case (state)
      ST_IDLE: if (candidate_valid) state_next = ST_BASE;
      ST_BASE: begin
        if (n < word_t'(4) || !n[0]) state_next = ST_OUT;
        else begin
          rctl.start = 1'b1;
          state_next = ST_RED;
        end
      end
      ST_RED: if (rsts.done) state_next = (rr == '0) ? ST_NEXT : ST_POWSQ_GO;
      ST_POWSQ_GO: begin
        if (e == '0) state_next = ST_CHK;
        else if (e[0]) begin
          mctl.start = 1'b1;
          state_next = ST_POWMUL_W;
        end else begin
          mctl.start = 1'b1;
          state_next = ST_POWSQ_W;
        end
      end
      ST_POWMUL_W: if (msts.done) state_next = ST_POWMUL_GO;
      ST_POWMUL_GO: begin
        mctl.start = 1'b1;
        state_next = ST_POWSQ_W;
      end
      ST_POWSQ_W: if (msts.done) state_next = ST_POWSQ_GO;
      ST_CHK: begin
        if (res == word_t'(1) || res == nm1) state_next = ST_NEXT;
        else if (k >= s) state_next = ST_OUT;
        else state_next = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        mctl.start = 1'b1;
        state_next = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (msts.done) begin
          if (mr == nm1) state_next = ST_NEXT;
          else if (mr <= word_t'(1) || k + CNT_BITS'(1) >= s) state_next = ST_OUT;
          else state_next = ST_SQ_GO;
        end
      end
      ST_NEXT: state_next = (widx + 3'd1 >= wcount(wset)) ? ST_OUT : ST_BASE;
      // Hold the verdict until the result register frees.
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_prime_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      is_prime_valid <= 1'b1;
      is_prime <= verdict;
    end else if (is_prime_valid && is_prime_ready) begin
      is_prime_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_sq <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (candidate_valid) begin
            n <= nin;
            nm1 <= nin_m1;
            s <= tz;
            widx <= '0;
            verdict <= 1'b1;
            if (nin < word_t'(LIM_SMALL)) wset <= SET_SMALL;
            else if (nin < word_t'(LIM_MID)) wset <= SET_MID;
            else wset <= SET_LARGE;
          end
        end
        ST_BASE: begin
          if (n < word_t'(4)) verdict <= (n > word_t'(1));
          else if (!n[0]) verdict <= 1'b0;
          e <= nm1 >> s;
          res <= word_t'(1);
          k <= CNT_BITS'(1);
        end
        ST_RED: if (rsts.done) pb <= rr;
        ST_POWSQ_GO: sel_sq <= !e[0];
        ST_POWMUL_W: if (msts.done) res <= mr;
        ST_POWMUL_GO: sel_sq <= 1'b1;
        ST_POWSQ_W: begin
          if (msts.done) begin
            pb <= mr;
            e <= e >> 1;
          end
        end
        ST_CHK: begin
          t <= res;
          if (!(res == word_t'(1) || res == nm1) && k >= s) verdict <= 1'b0;
        end
        ST_SQ_W: begin
          if (msts.done) begin
            t <= mr;
            k <= k + CNT_BITS'(1);
            if (mr != nm1 && (mr <= word_t'(1) || k + CNT_BITS'(1) >= s)) verdict <= 1'b0;
          end
        end
        ST_NEXT: widx <= widx + 3'd1;
        default: ;
      endcase
    end
  end

  assign candidate_ready = (state == ST_IDLE);
endmodule

// File: hdl/dpt_modmul.sv
// Bit-serial (a * b) mod m: one bit of b per cycle, MSB first.
module dpt_modmul import dpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_ctl_t ctl,
  input  word_t   a,
  input  word_t   b,
  input  word_t   m,
  output mm_sts_t sts,
  output word_t   r
);
  word_t bsh;
  logic [CNT_BITS-1:0] cnt;
  logic busy;
  word_t r1, r2;
  logic [VALUE_BITS:0] s1, s2;

  always_comb begin
    s1 = {1'b0, r} + {1'b0, r};
    r1 = (s1 >= {1'b0, m}) ? word_t'(s1 - {1'b0, m}) : word_t'(s1);
    s2 = {1'b0, r1} + {1'b0, a};
    r2 = bsh[VALUE_BITS-1] ?
         ((s2 >= {1'b0, m}) ? word_t'(s2 - {1'b0, m}) : word_t'(s2)) : r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      r <= '0;
      bsh <= b;
    end else if (busy) begin
      r <= r2;
      bsh <= bsh << 1;
    end
  end
endmodule

// File: hdl/dpt_modred.sv
// Restoring x mod m, one quotient bit per cycle.
module dpt_modred import dpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_ctl_t ctl,
  input  word_t   x,
  input  word_t   m,
  output mm_sts_t sts,
  output word_t   r
);
  word_t xs;
  logic [CNT_BITS-1:0] cnt;
  logic busy;
  logic [VALUE_BITS:0] sh;

  assign sh = {r, xs[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      r <= '0;
      xs <= x;
    end else if (busy) begin
      r <= (sh >= {1'b0, m}) ? word_t'(sh - {1'b0, m}) : word_t'(sh);
      xs <= xs << 1;
    end
  end
endmodule

// File: hdl/dpt_checker.sv
`include "assert_macros.svh"

module dpt_checker (
  input logic clk,
  input logic rst,
  input logic candidate_valid,
  input logic candidate_ready,
  input logic is_prime_valid,
  input logic is_prime_ready,
  input logic is_prime
);
  logic stall;

  assign stall = is_prime_valid && !is_prime_ready;

  `CHK_NEXT(a_out_hold, clk, rst, stall, is_prime_valid && $stable(is_prime))
  `CHK_IMPL(a_result_known, clk, rst, is_prime_valid, !$isunknown(is_prime))
  `CHK_NEXT(a_accept_busy, clk, rst, candidate_valid && candidate_ready, !candidate_ready)
endmodule

bind deterministic_primality_test dpt_checker u_chk (
  .clk, .rst, .candidate_valid, .candidate_ready, .is_prime_valid, .is_prime_ready, .is_prime
);

// File: test/testbench.sv
module testbench;
  import dpt_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_ITEMS = 15;
  localparam longint CYCLE_LIMIT = 40000000;

  logic        clk;
  logic        rst;
  logic        candidate_valid;
  logic        candidate_ready;
  logic [63:0] candidate;
  logic        is_prime_valid;
  logic        is_prime_ready;
  logic        is_prime;

  typedef struct {
    logic [63:0] value;
    int          answer;  // -1: take it from the predictor
  } vector_t;

  logic   verdict_q[$];
  int     errors;
  bit     quiet;
  longint cycles;

  deterministic_primality_test uut (
    .clk(clk),
    .rst(rst),
    .candidate_valid(candidate_valid),
    .candidate_ready(candidate_ready),
    .candidate(candidate),
    .is_prime_valid(is_prime_valid),
    .is_prime_ready(is_prime_ready),
    .is_prime(is_prime)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] r;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = add_mod(r, r, m);
      if (b[i]) r = add_mod(r, a, m);
    end
    return r;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 64'd1;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic bit strong_probe(logic [63:0] n, logic [63:0] base);
    logic [63:0] nm1, d, t;
    int s;
    nm1 = n - 1;
    d = nm1 >> 1;
    s = 1;
    base = base % n;
    if (base == 0) return 1'b1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    t = pow_mod(base, d, n);
    if (t == 64'd1 || t == nm1) return 1'b1;
    for (int k = 1; k < s; k++) begin
      t = mul_mod(t, t, n);
      if (t == nm1) return 1'b1;
      if (t <= 64'd1) break;
    end
    return 1'b0;
  endfunction

  function automatic logic primality(logic [63:0] n);
    logic [63:0] bases[7];
    int cnt;
    if (n < 64'd4) return n > 64'd1;
    if (!n[0]) return 1'b0;
    if (n < 64'd316349281) begin
      bases[0] = 64'd11000544;
      bases[1] = 64'd31481107;
      cnt = 2;
    end else if (n < 64'd4759123141) begin
      bases[0] = 64'd2;
      bases[1] = 64'd7;
      bases[2] = 64'd61;
      cnt = 3;
    end else begin
      bases[0] = 64'd2;
      bases[1] = 64'd325;
      bases[2] = 64'd9375;
      bases[3] = 64'd28178;
      bases[4] = 64'd450775;
      bases[5] = 64'd9780504;
      bases[6] = 64'd1795265022;
      cnt = 7;
    end
    for (int i = 0; i < cnt; i++)
      if (!strong_probe(n, bases[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly cheap candidates; a few wide ones keep the run short.
  function automatic logic [63:0] pick_candidate();
    int sel;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      v = rand64();
      v[0] = 1'b0;
    end else if (sel < 35) begin
      v = 64'($urandom_range(0, 3));
    end else if (sel < 85) begin
      v = 64'($urandom_range(5, 316349280)) | 64'd1;
    end else if (sel < 95) begin
      v = 64'd316349281 + 64'($urandom_range(0, 32'hFFFFFFFF));
      if (v >= 64'd4759123141) v = 64'd4759123139;
      v[0] = 1'b1;
    end else begin
      v = rand64() | 64'd1;
    end
    return v;
  endfunction

  task automatic send_candidate(logic [63:0] v, int answer);
    logic want;
    want = primality(v);
    if (answer >= 0 && want !== answer[0]) begin
      $display("%0t table mismatch for %0d: expected %0d actual %0d", $time, v, answer, want);
      errors++;
    end
    candidate_valid <= 1'b1;
    candidate <= v;
    do @(posedge clk); while (!(candidate_valid && candidate_ready));
    verdict_q.push_back(answer >= 0 ? answer[0] : want);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 17);
      candidate_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stall the result side in bursts, except at the end.
  initial begin
    int hold;
    is_prime_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 1) == 0) begin
        is_prime_ready <= 1'b1;
        hold = quiet ? 1 : $urandom_range(1, 17);
      end else begin
        is_prime_ready <= 1'b0;
        hold = $urandom_range(1, 17);
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && is_prime_valid && is_prime_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0b", $time, is_prime);
        errors++;
      end else begin
        logic want;
        want = verdict_q.pop_front();
        if (is_prime !== want) begin
          $display("%0t is_prime mismatch: expected %0b actual %0b", $time, want, is_prime);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("deterministic_primality_test test failed");
      $finish;
    end
  end

  initial begin
    vector_t vectors[$];
    vectors = '{
      '{64'd0, 0}, '{64'd1, 0}, '{64'd2, 1}, '{64'd3, 1}, '{64'd4, 0},
      '{64'd5, -1}, '{64'd9, -1}, '{64'd561, -1}, '{64'd31481107, -1},
      '{64'd11000544, 0}, '{64'd316349279, -1}, '{64'd316349281, -1},
      '{64'd2147483647, -1}, '{64'd3215031751, -1}, '{64'd4759123139, -1},
      '{64'd4759123141, -1}, '{64'd4759123143, -1},
      '{64'hFFFF_FFFF_FFFF_FFFE, 0}, '{64'hFFFF_FFFF_FFFF_FFFF, -1},
      '{64'd18446744073709551557, -1}, '{64'h8000_0000_0000_0000, 0},
      '{64'h5555_5555_5555_5554, 0}
    };
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    candidate_valid = 1'b0;
    candidate = 64'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (vectors[i]) begin
      idle_sender();
      send_candidate(vectors[i].value, vectors[i].answer);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      idle_sender();
      send_candidate(pick_candidate(), -1);
    end
    candidate_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("deterministic_primality_test test passed");
    end else begin
      $display("deterministic_primality_test test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/dpt_pkg.sv
hdl/dpt_modmul.sv
hdl/dpt_modred.sv
hdl/deterministic_primality_test.sv
hdl/dpt_checker.sv
test/testbench.sv
